FILE: rtl/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
// Depends on nothing; imported by smeu_core, stack_machine_execute_unit and the testbench.
`default_nettype none

package smeu_pkg;

   localparam int STACK_DEPTH  = 64;
   localparam int PC_WIDTH     = 16;
   localparam int DATA_W       = 32;
   localparam int SP_W         = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W       = $clog2(STACK_DEPTH);
   localparam int OP_W         = 4;
   localparam int NEXT_PC_W    = 16;
   localparam int COUNT_W      = 7;
   localparam int STATUS_W     = 2;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 56;
   localparam int RSP_USER_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_READ   = 4'd0,
      OP_ADD    = 4'd1,
      OP_WRITE  = 4'd2,
      OP_PUSH   = 4'd3,
      OP_DUP    = 4'd4,
      OP_JUMPIF = 4'd5,
      OP_MUL    = 4'd6,
      OP_SWAP   = 4'd7,
      OP_OVER   = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // Outcome of one instruction, as handed from the core to the result register.
   typedef struct packed {
      logic [NEXT_PC_W-1:0] next_pc;
      logic                 write_valid;
      logic [DATA_W-1:0]    write_value;
      status_type           status;
      logic [COUNT_W-1:0]   stack_count;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: input register, execute core and
// result register on stream channels. Depends on smeu_pkg and smeu_core.
//
//   Channel | Ports          | Direction | Contents
//   --------+----------------+-----------+-------------------------------------
//   request | req_t*         | in        | one instruction per transfer
//   result  | rsp_t*         | out       | one result per instruction
//
// An instruction is taken into the input register and executes as it moves into
// the result register, from which its result is offered on the result channel.
// One instruction per cycle is sustained while the result channel does not stall,
// with the one-port stack memory and the top three entries held in registers.
// While a result waits, one more instruction can be taken into the input register.
// Reset empties both registers and clears the stack depth and program counter.
`default_nettype none

module stack_machine_execute_unit
   import smeu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [31:0] operand, [63:32] read_value
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [3:0] req_type
   input  wire logic [OP_W-1:0]       req_tuser,

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] next_pc, [47:16] write_value, [54:48] stack_count, [55] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] write_valid, [2:1] status
   output      logic [RSP_USER_W-1:0] rsp_tuser
);

   logic              in_valid_ff, in_valid_in;
   logic [OP_W-1:0]   in_op_ff;
   logic [DATA_W-1:0] in_operand_ff;
   logic [DATA_W-1:0] in_read_ff;

   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;

   logic              advance;
   logic              exec_en;
   logic              req_xfer;

   assign advance    = !out_valid_ff || rsp_tready;
   assign exec_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (exec_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (exec_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff      <= req_tuser;
         in_operand_ff <= req_tdata[DATA_W-1:0];
         in_read_ff    <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (exec_en) begin
         out_ff <= result;
      end
   end

   smeu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .exec_en    (exec_en),
      .op         (in_op_ff),
      .operand    (in_operand_ff),
      .read_value (in_read_ff),
      .result     (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.stack_count, out_ff.write_value, out_ff.next_pc};
   assign rsp_tuser  = {out_ff.status, out_ff.write_valid};

endmodule

`default_nettype wire

FILE: rtl/smeu_core.sv
// Architectural state and execute logic: top two stack entries and a prefetched
// third entry in registers, deeper entries in a memory. Depends on smeu_pkg.
`default_nettype none

module smeu_core
   import smeu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              exec_en,
   input  wire logic [OP_W-1:0]   op,
   input  wire logic [DATA_W-1:0] operand,
   input  wire logic [DATA_W-1:0] read_value,
   output result_type             result
);

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];

   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic [DATA_W-1:0]   top_ff, top_in;
   logic [DATA_W-1:0]   nos_ff, nos_in;
   logic [DATA_W-1:0]   third_ff;

   logic [1:0]          need;
   logic                grow;
   logic                legal;
   logic                under;
   logic                over;
   logic                ok;
   logic                do_push;
   logic                do_pop;
   logic [DATA_W-1:0]   push_value;
   logic [DATA_W-1:0]   prod;
   logic [SP_W-1:0]     wr_ptr;
   logic [SP_W-1:0]     rd_ptr;
   logic                mem_we;
   logic                wvalid;
   logic [DATA_W-1:0]   wvalue;

   always_comb begin
      need  = 2'd0;
      grow  = 1'b0;
      legal = 1'b1;
      case (op)
         OP_READ, OP_PUSH: begin
            grow = 1'b1;
         end
         OP_DUP: begin
            need = 2'd1;
            grow = 1'b1;
         end
         OP_OVER: begin
            need = 2'd2;
            grow = 1'b1;
         end
         OP_ADD, OP_MUL, OP_SWAP: begin
            need = 2'd2;
         end
         OP_WRITE, OP_JUMPIF: begin
            need = 2'd1;
         end
         default: begin
            legal = 1'b0;
         end
      endcase
   end

   assign under = legal && (sp_ff < SP_W'(need));
   assign over  = legal && !under && grow && (sp_ff >= SP_W'(STACK_DEPTH));
   assign ok    = legal && !under && !over;

   assign prod = DATA_W'(top_ff * nos_ff);

   always_comb begin
      top_in     = top_ff;
      nos_in     = nos_ff;
      sp_in      = sp_ff;
      pc_in      = pc_ff + PC_WIDTH'(1);
      do_push    = 1'b0;
      do_pop     = 1'b0;
      push_value = operand;
      wvalid     = 1'b0;
      wvalue     = '0;
      if (ok) begin
         case (op)
            OP_READ: begin
               do_push    = 1'b1;
               push_value = read_value;
            end
            OP_PUSH: begin
               do_push    = 1'b1;
               push_value = operand;
            end
            OP_DUP: begin
               do_push    = 1'b1;
               push_value = top_ff;
            end
            OP_OVER: begin
               do_push    = 1'b1;
               push_value = nos_ff;
            end
            OP_ADD: begin
               do_pop = 1'b1;
               top_in = top_ff + nos_ff;
            end
            OP_MUL: begin
               do_pop = 1'b1;
               top_in = prod;
            end
            OP_SWAP: begin
               top_in = nos_ff;
               nos_in = top_ff;
            end
            OP_WRITE: begin
               do_pop = 1'b1;
               top_in = nos_ff;
               wvalid = 1'b1;
               wvalue = top_ff;
            end
            OP_JUMPIF: begin
               do_pop = 1'b1;
               top_in = nos_ff;
               if (!top_ff[DATA_W-1]) begin
                  pc_in = operand[PC_WIDTH-1:0];
               end
            end
            default: begin
            end
         endcase
         if (do_push) begin
            top_in = push_value;
            nos_in = top_ff;
            sp_in  = sp_ff + SP_W'(1);
         end
         if (do_pop) begin
            nos_in = third_ff;
            sp_in  = sp_ff - SP_W'(1);
         end
      end
   end

   // On a push the old second entry spills to memory; on a pop the entry that
   // becomes third is fetched from memory at the same edge.
   assign wr_ptr = sp_ff - SP_W'(2);
   assign rd_ptr = sp_ff - SP_W'(4);
   assign mem_we = exec_en && do_push && (sp_ff >= SP_W'(2));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_ptr[ADDR_W-1:0]] <= nos_ff;
      end
      if (exec_en && do_push) begin
         third_ff <= nos_ff;
      end else if (exec_en && do_pop) begin
         third_ff <= stack_mem[rd_ptr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         pc_ff <= '0;
      end else if (exec_en) begin
         sp_ff <= sp_in;
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         top_ff <= top_in;
         nos_ff <= nos_in;
      end
   end

   always_comb begin
      result.next_pc     = NEXT_PC_W'(pc_in);
      result.write_valid = wvalid;
      result.write_value = wvalue;
      result.status      = under ? ST_UNDER : (over ? ST_OVER : ST_OK);
      result.stack_count = COUNT_W'(sp_in);
   end

endmodule

`default_nettype wire

FILE: test/stack_machine_execute_unit_checker.sv
// Checker for the stack machine execute unit: watches the request and result streams,
// predicts each result from its own copy of the stack and counter, and compares.
// Depends on smeu_pkg for the opcode, status and result types.

module stack_machine_execute_unit_checker
   import smeu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    result_count,
   output int                    underflow_count,
   output int                    overflow_count,
   output int                    write_count,
   output int                    jump_count
);

   localparam int REPORT_LIMIT = 10;

   // Shadow machine state. Entries at or above stack_depth are never read.
   logic [DATA_W-1:0]   stack_words [0:STACK_DEPTH-1];
   int                  stack_depth;
   logic [PC_WIDTH-1:0] shadow_pc;

   result_type expected_results [$];

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      result_count    = 0;
      underflow_count = 0;
      overflow_count  = 0;
      write_count     = 0;
      jump_count      = 0;
      stack_depth     = 0;
      shadow_pc       = '0;
   end

   function automatic result_type execute_instruction(input logic [OP_W-1:0]   opcode,
                                                      input logic [DATA_W-1:0] operand,
                                                      input logic [DATA_W-1:0] read_value);
      result_type          outcome;
      int                  needed;
      bit                  grows;
      logic [DATA_W-1:0]   top_word;
      logic [DATA_W-1:0]   second_word;
      logic [PC_WIDTH-1:0] pc_after;

      needed = 0;
      grows  = 1'b0;
      case (opcode)
         OP_READ, OP_PUSH: grows = 1'b1;
         OP_DUP: begin
            needed = 1;
            grows  = 1'b1;
         end
         OP_OVER: begin
            needed = 2;
            grows  = 1'b1;
         end
         OP_ADD, OP_MUL, OP_SWAP: needed = 2;
         OP_WRITE, OP_JUMPIF: needed = 1;
         default: ;
      endcase

      outcome.status      = ST_OK;
      outcome.write_valid = 1'b0;
      outcome.write_value = '0;
      pc_after            = shadow_pc + 1'b1;

      // Opcodes above the last defined one fall through as a no-op.
      if (opcode <= OP_OVER) begin
         if (stack_depth < needed)
            outcome.status = ST_UNDER;
         else if (grows && stack_depth >= STACK_DEPTH)
            outcome.status = ST_OVER;
      end

      top_word    = (stack_depth >= 1) ? stack_words[stack_depth-1] : '0;
      second_word = (stack_depth >= 2) ? stack_words[stack_depth-2] : '0;

      if (opcode <= OP_OVER && outcome.status == ST_OK) begin
         case (opcode)
            OP_READ: begin
               stack_words[stack_depth] = read_value;
               stack_depth++;
            end
            OP_PUSH: begin
               stack_words[stack_depth] = operand;
               stack_depth++;
            end
            OP_DUP: begin
               stack_words[stack_depth] = top_word;
               stack_depth++;
            end
            OP_OVER: begin
               stack_words[stack_depth] = second_word;
               stack_depth++;
            end
            OP_ADD: begin
               stack_words[stack_depth-2] = top_word + second_word;
               stack_depth--;
            end
            OP_MUL: begin
               stack_words[stack_depth-2] = top_word * second_word;
               stack_depth--;
            end
            OP_SWAP: begin
               stack_words[stack_depth-1] = second_word;
               stack_words[stack_depth-2] = top_word;
            end
            OP_WRITE: begin
               outcome.write_valid = 1'b1;
               outcome.write_value = top_word;
               stack_depth--;
               write_count++;
            end
            OP_JUMPIF: begin
               stack_depth--;
               if (!top_word[DATA_W-1]) begin
                  pc_after = operand[PC_WIDTH-1:0];
                  jump_count++;
               end
            end
            default: ;
         endcase
      end

      if (outcome.status == ST_UNDER)
         underflow_count++;
      if (outcome.status == ST_OVER)
         overflow_count++;

      shadow_pc           = pc_after;
      outcome.next_pc     = pc_after;
      outcome.stack_count = COUNT_W'(stack_depth);
      return outcome;
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] wanted,
                                         input logic [63:0] seen);
      if (seen !== wanted) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch on %s in result %0d: expected %h, got %h",
                     field, result_count, wanted, seen);
      end
   endfunction

   always @(posedge clock) begin
      result_type wanted;

      if (reset) begin
         stack_depth = 0;
         shadow_pc   = '0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Result transfer %0d arrived with nothing outstanding: %h/%h",
                           result_count, rsp_tdata, rsp_tuser);
            end else begin
               wanted = expected_results.pop_front();
               compare_field("next_pc", 64'(wanted.next_pc), 64'(rsp_tdata[15:0]));
               compare_field("write_value", 64'(wanted.write_value),
                             64'(rsp_tdata[47:16]));
               compare_field("stack_count", 64'(wanted.stack_count),
                             64'(rsp_tdata[54:48]));
               compare_field("write_valid", 64'(wanted.write_valid), 64'(rsp_tuser[0]));
               compare_field("status", 64'(wanted.status), 64'(rsp_tuser[2:1]));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(execute_instruction(req_tuser, req_tdata[31:0],
                                                           req_tdata[63:32]));
      end
      pending_count = expected_results.size();
   end

endmodule

FILE: test/stack_machine_execute_unit_test.sv
// Top of the stack machine execute unit testbench: clock, reset, instruction stimulus
// under several traffic patterns and the verdict. Depends on smeu_pkg, the unit and
// stack_machine_execute_unit_checker.

module stack_machine_execute_unit_test;
   import smeu_pkg::*;

   localparam int ITEM_TARGET  = 500;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_WAIT  = 8;
   localparam int BURST_LENGTH = 68;

   localparam logic [OP_W-1:0] FIRST_SPARE_OP = 4'd9;
   localparam logic [OP_W-1:0] LAST_SPARE_OP  = 4'd15;

   localparam int SEQ_GROW   = 0;
   localparam int SEQ_SHRINK = 1;
   localparam int SEQ_MIXED  = 2;
   localparam int SEQ_NOISE  = 3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int sender_idle_pct;
   int receiver_stall_pct;
   int issued;
   int cycle_count;
   int mismatch_count;
   int pending_count;
   int result_count;
   int underflow_count;
   int overflow_count;
   int write_count;
   int jump_count;

   stack_machine_execute_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stack_machine_execute_unit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .underflow_count (underflow_count),
      .overflow_count  (overflow_count),
      .write_count     (write_count),
      .jump_count      (jump_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run hit the cycle limit with %0d results outstanding.", pending_count);
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Corner values show up often so that sums and products wrap and signs flip.
   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return DATA_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // Leaves tvalid high on return so that back-to-back transfers need no gap.
   task automatic issue_instruction(input logic [OP_W-1:0]   opcode,
                                    input logic [DATA_W-1:0] operand,
                                    input logic [DATA_W-1:0] read_value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {read_value, operand};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      issued++;
   endtask

   task automatic run_sequence(input int kind);
      int              length;
      logic [OP_W-1:0] opcode;

      case (kind)
         SEQ_GROW, SEQ_SHRINK: length = BURST_LENGTH;
         SEQ_NOISE:            length = $urandom_range(1, 3);
         default:              length = $urandom_range(8, 30);
      endcase
      repeat (length) begin
         case (kind)
            // A grow burst is long enough to fill the stack from empty and overflow it.
            SEQ_GROW:
               case ($urandom_range(0, 3))
                  0:       opcode = OP_READ;
                  1:       opcode = OP_PUSH;
                  2:       opcode = OP_DUP;
                  default: opcode = OP_OVER;
               endcase
            SEQ_SHRINK:
               case ($urandom_range(0, 3))
                  0:       opcode = OP_WRITE;
                  1:       opcode = OP_JUMPIF;
                  2:       opcode = OP_ADD;
                  default: opcode = OP_MUL;
               endcase
            SEQ_NOISE: opcode = OP_W'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP));
            default:
               if ($urandom_range(0, 19) == 0)
                  opcode = OP_W'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP));
               else
                  opcode = OP_W'($urandom_range(OP_READ, OP_OVER));
         endcase
         issue_instruction(opcode, random_word(), random_word());
      end
   endtask

   initial begin
      int phase_end;
      int pick;

      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = '0;
      rsp_tready         = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      issued             = 0;
      cycle_count        = 0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every operation that needs stack entries underflows on an empty stack, spare opcodes do nothing.
      issue_instruction(OP_ADD, 32'h0000_0001, 32'h0000_0002);
      issue_instruction(OP_WRITE, '0, '0);
      issue_instruction(OP_JUMPIF, 32'h0000_0040, '0);
      issue_instruction(OP_SWAP, '0, '0);
      issue_instruction(OP_OVER, '0, '0);
      issue_instruction(OP_DUP, '0, '0);
      issue_instruction(OP_MUL, '0, '0);
      issue_instruction(FIRST_SPARE_OP, '1, '1);
      issue_instruction(LAST_SPARE_OP, 32'h8000_0000, 32'h7FFF_FFFF);
      // Largest and smallest words, then a sum of all ones and a product that wraps.
      issue_instruction(OP_PUSH, 32'h7FFF_FFFF, '0);
      issue_instruction(OP_READ, 32'h1234_5678, 32'h8000_0000);
      issue_instruction(OP_OVER, '0, '0);
      issue_instruction(OP_ADD, '0, '0);
      issue_instruction(OP_SWAP, '0, '0);
      issue_instruction(OP_DUP, '0, '0);
      issue_instruction(OP_MUL, '0, '0);
      // Taken jump keeps only the low counter bits; a negative top falls through.
      issue_instruction(OP_JUMPIF, 32'hDEAD_1234, '1);
      issue_instruction(OP_JUMPIF, 32'h0000_BEEF, '0);
      issue_instruction(OP_PUSH, '0, '1);
      issue_instruction(OP_JUMPIF, '1, '0);
      // The counter now sits at its top value and wraps on the next instruction.
      issue_instruction(OP_PUSH, 32'h8000_0000, '0);
      issue_instruction(OP_WRITE, '1, '1);
      issue_instruction(OP_READ, '0, '1);
      issue_instruction(OP_WRITE, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 69;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 69;
            end
            default: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 29;
            end
         endcase
         phase_end = ITEM_TARGET * (phase + 1) / 4;
         // Alternate a fill to overflow and a drain to underflow at each phase start.
         run_sequence((phase % 2 == 0) ? SEQ_GROW : SEQ_SHRINK);
         while (issued < phase_end) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               run_sequence(SEQ_GROW);
            else if (pick == 1)
               run_sequence(SEQ_SHRINK);
            else if (pick <= 3)
               run_sequence(SEQ_NOISE);
            else
               run_sequence(SEQ_MIXED);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);

      $display("Issued %0d instructions over four traffic patterns; checked %0d results.",
               issued, result_count);
      $display("Covered %0d underflows, %0d overflows, %0d writes and %0d taken jumps.",
               underflow_count, overflow_count, write_count, jump_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
